// File: hdl/spl_pkg.sv
`default_nettype none
package spl_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int NODE_W = 16;
  localparam int PRIO_W = 20;
  localparam int KIND_W = 3;
  localparam int NODE_OUT_W = NODE_W + 1;

  localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP_FIRST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_LAST = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CONTAINS = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  // marks a removal that found nothing, or a request that removes nothing
  localparam logic [NODE_OUT_W-1:0] NODE_NONE = '1;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;        // insert, list not full
    logic pop_first;  // remove lowest, list not empty
    logic pop_last;   // remove highest, list not empty
    logic clr;        // empty the list
  } spl_ctl_t;

endpackage
`default_nettype wire

// File: hdl/spl_cell.sv
`default_nettype none
module spl_cell
  import spl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spl_ctl_t          ctl,
  input  wire logic [NODE_W-1:0] node_in,
  input  wire logic [PRIO_W-1:0] prio_in,
  // left neighbor (lower priority side)
  input  wire logic [NODE_W-1:0] left_node,
  input  wire logic [PRIO_W-1:0] left_prio,
  input  wire logic              left_valid,
  input  wire logic              left_stay,
  // right neighbor (higher priority side)
  input  wire logic [NODE_W-1:0] right_node,
  input  wire logic [PRIO_W-1:0] right_prio,
  input  wire logic              right_valid,
  output logic [NODE_W-1:0]      node,
  output logic [PRIO_W-1:0]      prio,
  output logic                   valid,
  output logic                   stay,
  output logic                   match,
  output logic [NODE_W-1:0]      last_node
);

  // entry keeps its place on insert when it sorts at or below the new key
  assign stay = valid && (prio <= prio_in);
  assign match = valid && (node == node_in);
  assign last_node = (valid && !right_valid) ? node : '0;

  always_ff @(posedge clk) begin
    if (ctl.ins && !stay) begin
      if (left_stay) begin
        node <= node_in;
        prio <= prio_in;
      end else begin
        node <= left_node;
        prio <= left_prio;
      end
    end else if (ctl.pop_first) begin
      node <= right_node;
      prio <= right_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clr) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      valid <= valid | left_valid;
    end else if (ctl.pop_first || ctl.pop_last) begin
      valid <= right_valid;
    end
  end

endmodule
`default_nettype wire

// File: hdl/sorted_priority_list.sv
// channel   | signals                                         | handshake
// ----------+-------------------------------------------------+-------------------------
// request   | kind, node, priority_req                        | start high, busy low
// result    | node_out, ok, count, full_res, empty_res        | done high for one cycle
//
// for every request the accept edge registers the command, and the next
// edge updates the whole cell row at once and registers the result (done high)
// busy is high for the one cycle between them; the next request may be accepted
// at the edge that ends the done cycle
// rst (synchronous) empties the list; stored nodes and priorities are not cleared
// the result cannot be held off: it is valid only while done is high
`default_nettype none
module sorted_priority_list
  import spl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [KIND_W-1:0]            kind,
  input  wire logic [NODE_W-1:0]            node,
  input  wire logic [PRIO_W-1:0]            priority_req,
  output logic                              done,
  output logic signed [NODE_OUT_W-1:0]      node_out,
  output logic                              ok,
  output logic [CNT_W-1:0]                  count,
  output logic                              full_res,
  output logic                              empty_res
);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // registered request
  logic              pend;
  logic              chk;
  spl_ctl_t          ctl;
  logic [NODE_W-1:0] node_q;
  logic [PRIO_W-1:0] prio_q;

  // live entry count, separate from the count result port
  logic [CNT_W-1:0]  entries;
  logic [CNT_W-1:0]  entries_next;

  spl_ctl_t ctl_next;
  logic     accept;

  // cell row
  logic [NODE_W-1:0] cell_node  [DEPTH];
  logic [PRIO_W-1:0] cell_prio  [DEPTH];
  logic [DEPTH-1:0]  cell_valid;
  logic [DEPTH-1:0]  cell_stay;
  logic [DEPTH-1:0]  cell_match;
  logic [DEPTH-1:0]  last_col   [NODE_W];
  logic [NODE_W-1:0] last_node;
  logic              hit;

  assign busy = pend;
  assign accept = start && !pend;

  // decode against the current count so the cells see only legal commands
  always_comb begin
    ctl_next = '0;
    case (kind)
      KIND_INSERT:    ctl_next.ins = (entries != CNT_FULL);
      KIND_POP_FIRST: ctl_next.pop_first = (entries != '0);
      KIND_POP_LAST:  ctl_next.pop_last = (entries != '0);
      KIND_CLEAR:     ctl_next.clr = 1'b1;
      default:        ctl_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      chk  <= 1'b0;
      ctl  <= '0;
    end else begin
      pend <= accept;
      chk  <= accept && (kind == KIND_CONTAINS);
      ctl  <= accept ? ctl_next : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      node_q <= node;
      prio_q <= priority_req;
    end
  end

  genvar gi, gb;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [NODE_W-1:0] l_node;
      logic [PRIO_W-1:0] l_prio;
      logic              l_valid;
      logic              l_stay;
      logic [NODE_W-1:0] r_node;
      logic [PRIO_W-1:0] r_prio;
      logic              r_valid;
      logic [NODE_W-1:0] c_last;

      if (gi == 0) begin : g_head
        // the head slot behaves as if an entry that always stays sits before it
        assign l_node  = '0;
        assign l_prio  = '0;
        assign l_valid = 1'b1;
        assign l_stay  = 1'b1;
      end else begin : g_mid
        assign l_node  = cell_node[gi-1];
        assign l_prio  = cell_prio[gi-1];
        assign l_valid = cell_valid[gi-1];
        assign l_stay  = cell_stay[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign r_node  = '0;
        assign r_prio  = '0;
        assign r_valid = 1'b0;
      end else begin : g_body
        assign r_node  = cell_node[gi+1];
        assign r_prio  = cell_prio[gi+1];
        assign r_valid = cell_valid[gi+1];
      end

      spl_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctl         (ctl),
        .node_in     (node_q),
        .prio_in     (prio_q),
        .left_node   (l_node),
        .left_prio   (l_prio),
        .left_valid  (l_valid),
        .left_stay   (l_stay),
        .right_node  (r_node),
        .right_prio  (r_prio),
        .right_valid (r_valid),
        .node        (cell_node[gi]),
        .prio        (cell_prio[gi]),
        .valid       (cell_valid[gi]),
        .stay        (cell_stay[gi]),
        .match       (cell_match[gi]),
        .last_node   (c_last)
      );

      for (gb = 0; gb < NODE_W; gb++) begin : g_col
        assign last_col[gb][gi] = c_last[gb];
      end
    end

    // only the last occupied cell drives its node, so an or tree selects it
    for (gb = 0; gb < NODE_W; gb++) begin : g_or
      assign last_node[gb] = |last_col[gb];
    end
  endgenerate

  assign hit = |cell_match;

  always_comb begin
    entries_next = entries;
    if (ctl.clr) begin
      entries_next = '0;
    end else if (ctl.ins) begin
      entries_next = entries + CNT_W'(1);
    end else if (ctl.pop_first || ctl.pop_last) begin
      entries_next = entries - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries <= '0;
      done    <= 1'b0;
    end else begin
      entries <= entries_next;
      done    <= pend;
    end
  end

  // result registers, loaded in the cycle the cells update
  always_ff @(posedge clk) begin
    if (pend) begin
      if (ctl.pop_first) begin
        node_out <= {1'b0, cell_node[0]};
      end else if (ctl.pop_last) begin
        node_out <= {1'b0, last_node};
      end else begin
        node_out <= NODE_NONE;
      end
      ok        <= ctl.ins || ctl.pop_first || ctl.pop_last || ctl.clr || (chk && hit);
      count     <= entries_next;
      full_res  <= (entries_next == CNT_FULL);
      empty_res <= (entries_next == '0);
    end
  end

endmodule
`default_nettype wire
